// File: rtl/ida_pkg.sv
package ida_pkg;

  localparam int SAMPLE_BITS    = 16;
  localparam int FRAC_BITS      = 16;
  localparam int COUNT_BITS     = 24;
  localparam int LOG_TABLE_BITS = 10;

  localparam int TAB_DEPTH    = 1 << LOG_TABLE_BITS;
  localparam int POS_BITS     = $clog2(SAMPLE_BITS);
  localparam int LOG_BITS     = POS_BITS + FRAC_BITS;
  localparam int LNMAG_BITS   = LOG_BITS;
  localparam int TERM_BITS    = SAMPLE_BITS + LNMAG_BITS;
  localparam int CONTRIB_BITS = TERM_BITS + 4;
  localparam int SUM_BITS     = 64;
  localparam int CNT_BITS     = COUNT_BITS + 1;
  localparam int MEAN_BITS    = 36;
  localparam int QUEUE_DEPTH  = 4;

  localparam logic [31:0] LN2_Q32 = 32'd2977044472;

  typedef logic [FRAC_BITS-1:0] frac_tab_t [TAB_DEPTH];

  typedef struct packed {
    logic signed [CONTRIB_BITS-1:0] contrib;
    logic                           mask;
    logic                           last;
  } ida_item_t;

  typedef enum logic [1:0] {
    ST_ACC,
    ST_DIV,
    ST_WAIT
  } back_state_e;

  // Fraction table: log2(1 + i/2^LOG_TABLE_BITS) by repeated squaring of a Q.30 mantissa.
  function automatic frac_tab_t build_frac_tab();
    frac_tab_t            t;
    logic [63:0]          m;
    logic [FRAC_BITS-1:0] r;
    for (int i = 0; i < TAB_DEPTH; i++) begin
      m = (64'd1 << 30) + (64'(i) << (30 - LOG_TABLE_BITS));
      r = '0;
      for (int b = 0; b < FRAC_BITS; b++) begin
        m = (m * m) >> 30;
        r = r << 1;
        if (m >= (64'd1 << 31)) begin
          r[0] = 1'b1;
          m    = m >> 1;
        end
      end
      t[i] = r;
    end
    return t;
  endfunction

  localparam frac_tab_t FRAC_TAB = build_frac_tab();

endpackage

// File: rtl/i_divergence_accumulator_unit.sv
// I-divergence accumulator.
// Input channel: an item (first_sample_i, second_sample_i, pixel_mask_i,
// last_pixel_i) is taken at a rising edge where push is high and full is low.
// Result channel: while empty is low, mean_divergence_o and pixel_count_o hold
// the oldest result; it is taken at an edge where pop is high and empty is low.
// A front pipeline of three stages computes the log terms and the per-pixel
// contribution, and a four-entry queue hands each request to the back end.
// The back end adds one contribution per cycle while accumulating, so a stream
// of ordinary pixels flows at one per cycle. A last pixel starts a restoring
// division of the sum by the count; no further pixel is accumulated until its
// result is in the output register. When the receiver stalls the finished
// result waits in the output register; the back end keeps accumulating the
// next image and holds the next division's result until the register frees;
// full rises once the queue is full and the front's last stage holds an item.
// Reset clears the sum, the count, the queue and all valid flags.
module i_divergence_accumulator_unit import ida_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   push,
  output logic                   full,
  input  logic [15:0]            first_sample_i,
  input  logic [15:0]            second_sample_i,
  input  logic                   pixel_mask_i,
  input  logic                   last_pixel_i,
  output logic                   empty,
  input  logic                   pop,
  output logic [MEAN_BITS-1:0]   mean_divergence_o,
  output logic [CNT_BITS-1:0]    pixel_count_o
);

  logic      fr_ready, fq_valid, fq_ready, qb_valid, qb_ready;
  ida_item_t fq_item, qb_item;

  assign full = !fr_ready;

  // Front end: log2 of both samples, scaled log difference, contribution.
  ida_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (push),
    .in_ready_o  (fr_ready),
    .x_i         (first_sample_i[SAMPLE_BITS-1:0]),
    .y_i         (second_sample_i[SAMPLE_BITS-1:0]),
    .mask_i      (pixel_mask_i),
    .last_i      (last_pixel_i),
    .out_valid_o (fq_valid),
    .out_ready_i (fq_ready),
    .out_item_o  (fq_item)
  );

  // Queue that decouples the front pipeline from the accumulator.
  ida_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (fq_valid),
    .wr_ready_o (fq_ready),
    .wr_item_i  (fq_item),
    .rd_valid_o (qb_valid),
    .rd_ready_i (qb_ready),
    .rd_item_o  (qb_item)
  );

  // Back end: saturating accumulation, count, division and result register.
  ida_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (qb_valid),
    .in_ready_o (qb_ready),
    .in_item_i  (qb_item),
    .empty      (empty),
    .pop        (pop),
    .mean_o     (mean_divergence_o),
    .count_o    (pixel_count_o)
  );

endmodule

// File: rtl/ida_front.sv
module ida_front import ida_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic [SAMPLE_BITS-1:0] x_i,
  input  logic [SAMPLE_BITS-1:0] y_i,
  input  logic                   mask_i,
  input  logic                   last_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output ida_item_t              out_item_o
);

  function automatic logic [LOG_BITS-1:0] log2q(input logic [SAMPLE_BITS-1:0] v);
    logic [POS_BITS-1:0]                   p;
    logic [SAMPLE_BITS+LOG_TABLE_BITS-1:0] sh;
    p = '0;
    for (int k = 0; k < SAMPLE_BITS; k++) begin
      if (v[k]) p = POS_BITS'(k);
    end
    sh = {v, {LOG_TABLE_BITS{1'b0}}} >> p;
    return {p, FRAC_TAB[sh[LOG_TABLE_BITS-1:0]]};
  endfunction

  logic                   en;
  logic                   v1_q, v2_q, v3_q;
  logic [SAMPLE_BITS-1:0] x1_q, y1_q, x2_q, y2_q;
  logic                   m1_q, l1_q, nz1_q, m2_q, l2_q, nz2_q;
  logic [LOG_BITS-1:0]    lx1_q, ly1_q;
  logic                   below2_q;
  logic [LNMAG_BITS-1:0]  lnmag2_q;
  ida_item_t              item3_q;

  logic [LOG_BITS-1:0]        mag;
  logic [LOG_BITS+32-1:0]     prod;
  logic [TERM_BITS-1:0]       term;
  logic signed [CONTRIB_BITS-1:0] contrib;

  // The whole pipeline moves unless the last stage holds an item the queue cannot take.
  assign en          = !v3_q || out_ready_i;
  assign in_ready_o  = en;
  assign out_valid_o = v3_q;
  assign out_item_o  = item3_q;

  always_comb begin
    mag  = (lx1_q < ly1_q) ? (ly1_q - lx1_q) : (lx1_q - ly1_q);
    prod = (LOG_BITS+32)'(mag) * (LOG_BITS+32)'(LN2_Q32) + ((LOG_BITS+32)'(1) << 31);
    term = TERM_BITS'(x2_q) * TERM_BITS'(lnmag2_q);
    contrib = $signed(CONTRIB_BITS'(y2_q) << FRAC_BITS);
    if (nz2_q) begin
      contrib = contrib - $signed(CONTRIB_BITS'(x2_q) << FRAC_BITS);
      if (below2_q) begin
        contrib = contrib - $signed(CONTRIB_BITS'(term));
      end else begin
        contrib = contrib + $signed(CONTRIB_BITS'(term));
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (en) begin
      v1_q <= in_valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      x1_q     <= x_i;
      y1_q     <= y_i;
      m1_q     <= mask_i;
      l1_q     <= last_i;
      nz1_q    <= (x_i != '0) && (y_i != '0);
      lx1_q    <= log2q(x_i);
      ly1_q    <= log2q(y_i);
      x2_q     <= x1_q;
      y2_q     <= y1_q;
      m2_q     <= m1_q;
      l2_q     <= l1_q;
      nz2_q    <= nz1_q;
      below2_q <= lx1_q < ly1_q;
      lnmag2_q <= prod[LOG_BITS+32-1:32];
      item3_q.contrib <= contrib;
      item3_q.mask    <= m2_q;
      item3_q.last    <= l2_q;
    end
  end

endmodule

// File: rtl/ida_queue.sv
module ida_queue import ida_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      wr_valid_i,
  output logic      wr_ready_o,
  input  ida_item_t wr_item_i,
  output logic      rd_valid_o,
  input  logic      rd_ready_i,
  output ida_item_t rd_item_o
);

  localparam int PTR_BITS = $clog2(QUEUE_DEPTH);

  ida_item_t           mem_q [QUEUE_DEPTH];
  logic [PTR_BITS-1:0] wp_q, rp_q;
  logic [PTR_BITS:0]   cnt_q;
  logic                wr, rd;

  assign wr_ready_o = cnt_q != (PTR_BITS+1)'(QUEUE_DEPTH);
  assign rd_valid_o = cnt_q != '0;
  assign wr         = wr_valid_i && wr_ready_o;
  assign rd         = rd_valid_o && rd_ready_i;
  assign rd_item_o  = mem_q[rp_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (wr) wp_q <= wp_q + 1'b1;
      if (rd) rp_q <= rp_q + 1'b1;
      cnt_q <= cnt_q + (PTR_BITS+1)'(wr) - (PTR_BITS+1)'(rd);
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr) mem_q[wp_q] <= wr_item_i;
  end

endmodule

// File: rtl/ida_back.sv
module ida_back import ida_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  ida_item_t            in_item_i,
  output logic                 empty,
  input  logic                 pop,
  output logic [MEAN_BITS-1:0] mean_o,
  output logic [CNT_BITS-1:0]  count_o
);

  localparam int STEP_BITS = $clog2(SUM_BITS);

  back_state_e state_q, state_d;

  logic signed [SUM_BITS-1:0] sum_q;
  logic [CNT_BITS-1:0]        cnt_q;
  logic [SUM_BITS-1:0]        quo_q;
  logic [CNT_BITS:0]          rem_q;
  logic [CNT_BITS-1:0]        dvs_q, cnt_hold_q;
  logic [STEP_BITS-1:0]       step_q;
  logic                       out_v_q;
  logic [MEAN_BITS-1:0]       mean_q;
  logic [CNT_BITS-1:0]        cnt_out_q;

  logic                       take, start_div, finish;
  logic signed [SUM_BITS:0]   wide;
  logic signed [SUM_BITS-1:0] sum_new;
  logic [CNT_BITS-1:0]        cnt_new;
  logic [CNT_BITS+1:0]        rem_sh;
  logic                       ge;

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_ACC:  if (in_valid_i && in_item_i.last) state_d = ST_DIV;
      ST_DIV:  if (step_q == STEP_BITS'(SUM_BITS-1)) state_d = ST_WAIT;
      ST_WAIT: if (!out_v_q || pop) state_d = ST_ACC;
      default: state_d = ST_ACC;
    endcase
  end

  // Outputs of the sequencer.
  always_comb begin
    take      = 1'b0;
    finish    = 1'b0;
    unique case (state_q)
      ST_ACC:  take   = in_valid_i;
      ST_WAIT: finish = !out_v_q || pop;
      default: ;
    endcase
    start_div = take && in_item_i.last;
  end

  assign in_ready_o = state_q == ST_ACC;

  always_comb begin
    wide = {sum_q[SUM_BITS-1], sum_q} +
           (SUM_BITS+1)'($signed(in_item_i.contrib));
    if (wide[SUM_BITS] != wide[SUM_BITS-1]) begin
      sum_new = wide[SUM_BITS] ? {1'b1, {(SUM_BITS-1){1'b0}}} : {1'b0, {(SUM_BITS-1){1'b1}}};
    end else begin
      sum_new = wide[SUM_BITS-1:0];
    end
    cnt_new = cnt_q;
    if (!in_item_i.mask) begin
      sum_new = sum_q;
    end else if (cnt_q < (CNT_BITS'(1) << COUNT_BITS)) begin
      cnt_new = cnt_q + 1'b1;
    end
    rem_sh = {rem_q, quo_q[SUM_BITS-1]};
    ge     = rem_sh >= (CNT_BITS+2)'(dvs_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_ACC;
      sum_q   <= '0;
      cnt_q   <= '0;
      out_v_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (start_div) begin
        sum_q <= '0;
        cnt_q <= '0;
      end else if (take) begin
        sum_q <= sum_new;
        cnt_q <= cnt_new;
      end
      if (finish) out_v_q <= 1'b1;
      else if (pop) out_v_q <= 1'b0;
    end
  end

  // Restoring division, one quotient bit per cycle.
  always_ff @(posedge clk_i) begin
    if (start_div) begin
      step_q     <= '0;
      rem_q      <= '0;
      cnt_hold_q <= cnt_new;
      if (cnt_new != '0 && sum_new > 0) begin
        quo_q <= SUM_BITS'(sum_new);
        dvs_q <= cnt_new;
      end else begin
        quo_q <= '0;
        dvs_q <= CNT_BITS'(1);
      end
    end else if (state_q == ST_DIV) begin
      step_q <= step_q + 1'b1;
      quo_q  <= {quo_q[SUM_BITS-2:0], ge};
      rem_q  <= ge ? (CNT_BITS+1)'(rem_sh - (CNT_BITS+2)'(dvs_q)) : rem_sh[CNT_BITS:0];
    end
    if (finish) begin
      mean_q    <= (quo_q > SUM_BITS'({MEAN_BITS{1'b1}})) ? {MEAN_BITS{1'b1}}
                                                         : quo_q[MEAN_BITS-1:0];
      cnt_out_q <= cnt_hold_q;
    end
  end

  assign empty   = !out_v_q;
  assign mean_o  = mean_q;
  assign count_o = cnt_out_q;

endmodule

// File: tb/i_divergence_accumulator_unit_test.sv
`timescale 1ns / 1ps

// Checks the I-divergence accumulator against a cycle-free predictor of the
// per-pixel fixed-point arithmetic, one expected mean per image.
module i_divergence_accumulator_unit_test;
  import ida_pkg::*;

  localparam int          RANDOM_PIXELS = 1550;
  localparam int          CYCLE_LIMIT   = 1000000;
  localparam int          LONG_HOLD     = 600;
  localparam logic [63:0] LN2_FIX       = 64'd2977044472;
  localparam logic [63:0] MEAN_CEIL     = (64'd1 << MEAN_BITS) - 64'd1;
  localparam logic [63:0] COUNT_CEIL    = 64'd1 << COUNT_BITS;

  typedef struct {
    logic [15:0] x;
    logic [15:0] y;
    logic        mask;
    logic        last;
    logic        drain;  // Sender waits for every outstanding result first.
  } pixel_req_t;

  typedef struct {
    logic [MEAN_BITS-1:0] mean;
    logic [CNT_BITS-1:0]  count;
  } image_result_t;

  logic                 clk_i           = 1'b0;
  logic                 rst_ni          = 1'b0;
  logic                 push            = 1'b0;
  logic                 full;
  logic [15:0]          first_sample_i  = '0;
  logic [15:0]          second_sample_i = '0;
  logic                 pixel_mask_i    = 1'b0;
  logic                 last_pixel_i    = 1'b0;
  logic                 empty;
  logic                 pop             = 1'b0;
  logic [MEAN_BITS-1:0] mean_divergence_o;
  logic [CNT_BITS-1:0]  pixel_count_o;

  i_divergence_accumulator_unit uut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .push              (push),
    .full              (full),
    .first_sample_i    (first_sample_i),
    .second_sample_i   (second_sample_i),
    .pixel_mask_i      (pixel_mask_i),
    .last_pixel_i      (last_pixel_i),
    .empty             (empty),
    .pop               (pop),
    .mean_divergence_o (mean_divergence_o),
    .pixel_count_o     (pixel_count_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Predictor state: the running sum and count mirror what the block holds
  // between two last pixels.
  logic [FRAC_BITS-1:0] log_fraction [TAB_DEPTH];
  logic signed [63:0]   sum_model;
  logic [63:0]          count_model;
  pixel_req_t           pending_pixels [$];
  image_result_t        expected_means [$];

  int unsigned cycles      = 0;
  int unsigned mismatches  = 0;
  int unsigned pixels_sent = 0;
  int unsigned images_seen = 0;
  int unsigned zero_pairs  = 0;
  int unsigned empty_means = 0;
  bit          saw_full    = 1'b0;

  // The monitor records each edge's handshakes so the driver and the
  // receiver know at the following falling edge what was taken.
  bit req_taken = 1'b0;
  bit res_taken = 1'b0;

  // log2(1 + i/2^LOG_TABLE_BITS) by repeated squaring of a Q.30 mantissa,
  // truncating the product back to Q.30 after every step.
  function automatic logic [FRAC_BITS-1:0] fraction_entry(int i);
    logic [63:0]          m;
    logic [FRAC_BITS-1:0] r;
    m = (64'd1 << 30) + (64'(i) << (30 - LOG_TABLE_BITS));
    r = '0;
    for (int b = 0; b < FRAC_BITS; b++) begin
      m = (m * m) >> 30;
      r = {r[FRAC_BITS-2:0], 1'b0};
      if (m >= (64'd2 << 30)) begin
        r[0] = 1'b1;
        m    = m >> 1;
      end
    end
    return r;
  endfunction

  // Leading-one position in the integer part, table lookup for the fraction.
  function automatic logic [63:0] log2_fixed(logic [63:0] v);
    int          lead;
    logic [63:0] idx;
    lead = 0;
    for (int k = 0; k < SAMPLE_BITS; k++) begin
      if (v[k]) lead = k;
    end
    idx = ((v << LOG_TABLE_BITS) >> lead) & ((64'd1 << LOG_TABLE_BITS) - 1);
    return (64'(lead) << FRAC_BITS) + 64'(log_fraction[idx]);
  endfunction

  // Signed Q.FRAC_BITS contribution x*ln(x/y) - x + y, or just y when either
  // sample is zero.
  function automatic logic signed [63:0] pixel_divergence(logic [63:0] x, logic [63:0] y);
    logic [63:0] gain;
    logic [63:0] loss;
    logic [63:0] lx;
    logic [63:0] ly;
    logic [63:0] log_gap;
    logic [63:0] ln_mag;
    gain = y << FRAC_BITS;
    loss = '0;
    if (x != 0 && y != 0) begin
      lx      = log2_fixed(x);
      ly      = log2_fixed(y);
      log_gap = (lx < ly) ? ly - lx : lx - ly;
      ln_mag  = (log_gap * LN2_FIX + (64'd1 << 31)) >> 32;
      loss    = x << FRAC_BITS;
      if (lx < ly) loss = loss + x * ln_mag;
      else gain = gain + x * ln_mag;
    end
    return $signed(gain) - $signed(loss);
  endfunction

  // Folds one accepted request into the running sum and, on the last pixel,
  // queues the mean that the block must report.
  task automatic absorb_pixel(pixel_req_t p);
    logic signed [63:0] c;
    logic signed [63:0] top;
    logic signed [63:0] bottom;
    image_result_t      r;
    logic [63:0]        mean;
    top    = 64'sh7FFF_FFFF_FFFF_FFFF;
    bottom = 64'sh8000_0000_0000_0000;
    if (p.mask) begin
      if (p.x == 0 || p.y == 0) zero_pairs++;
      c = pixel_divergence(64'(p.x), 64'(p.y));
      if (c > 0 && sum_model > top - c) sum_model = top;
      else if (c < 0 && sum_model < bottom - c) sum_model = bottom;
      else sum_model = sum_model + c;
      if (count_model < COUNT_CEIL) count_model++;
    end
    if (p.last) begin
      mean = '0;
      if (count_model > 0 && sum_model > 0) begin
        mean = 64'(sum_model) / count_model;
        if (mean > MEAN_CEIL) mean = MEAN_CEIL;
      end
      if (mean == 0) empty_means++;
      r.mean  = mean[MEAN_BITS-1:0];
      r.count = count_model[CNT_BITS-1:0];
      expected_means.insert(expected_means.size(), r);
      sum_model   = '0;
      count_model = '0;
    end
  endtask

  task automatic queue_pixel(logic [15:0] x, logic [15:0] y, logic m, logic l, logic d);
    pixel_req_t p;
    p.x     = x;
    p.y     = y;
    p.mask  = m;
    p.last  = l;
    p.drain = d;
    pending_pixels.insert(pending_pixels.size(), p);
  endtask

  // Samples span every magnitude so small values and zeros show up often.
  function automatic logic [15:0] random_sample();
    int unsigned w;
    w = $urandom_range(0, 16);
    if ($urandom_range(0, 15) == 0) return 16'hFFFF;
    return 16'($urandom & ((32'd1 << w) - 1));
  endfunction

  // Monitor: everything is sampled at the rising edge, before the block's
  // own updates land.
  always @(posedge clk_i) begin
    image_result_t want;
    pixel_req_t    got;
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("i_divergence_accumulator_unit test failed");
      $finish;
    end
    req_taken = rst_ni && push && !full;
    res_taken = rst_ni && pop && !empty;
    if (rst_ni && full) saw_full = 1'b1;
    if (req_taken) begin
      got.x    = first_sample_i;
      got.y    = second_sample_i;
      got.mask = pixel_mask_i;
      got.last = last_pixel_i;
      got.drain = 1'b0;
      absorb_pixel(got);
    end
    if (res_taken) begin
      images_seen++;
      if (expected_means.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: mean %0h count %0d", mean_divergence_o, pixel_count_o);
      end else begin
        want = expected_means.pop_front();
        if (want.mean !== mean_divergence_o || want.count !== pixel_count_o) begin
          mismatches++;
          if (mismatches <= 10)
            $display("image %0d: expected mean %0h count %0d, got mean %0h count %0d",
                     images_seen, want.mean, want.count, mean_divergence_o, pixel_count_o);
        end
      end
    end
  end

  // Driver: pulls requests from the pending queue and offers each after a
  // random number of idle cycles. Every fourth run of 40 requests has no gaps.
  pixel_req_t  cur_pixel;
  bit          has_pixel = 1'b0;
  int unsigned push_wait = 0;

  always @(negedge clk_i) begin
    logic next_push;
    if (req_taken) begin
      has_pixel = 1'b0;
      pixels_sent++;
    end
    if (rst_ni && !has_pixel && pending_pixels.size() != 0 &&
        !(pending_pixels[0].drain && expected_means.size() != 0)) begin
      cur_pixel = pending_pixels.pop_front();
      has_pixel = 1'b1;
      push_wait = ((pixels_sent / 40) % 4 == 1) ? 0 : $urandom_range(0, 16);
    end
    if (has_pixel && push_wait > 0) begin
      push_wait--;
      next_push = 1'b0;
    end else begin
      next_push = has_pixel;
    end
    push            <= next_push;
    first_sample_i  <= cur_pixel.x;
    second_sample_i <= cur_pixel.y;
    pixel_mask_i    <= cur_pixel.mask;
    last_pixel_i    <= cur_pixel.last;
  end

  // Receiver: a random delay before each pop, gap-free for some images, and
  // one long hold-off so the output register, the internal queue and finally
  // the input all back up while the sender keeps offering pixels.
  int unsigned pop_wait  = 0;
  int unsigned hold_left = 0;
  bit          held_once = 1'b0;

  always @(negedge clk_i) begin
    if (res_taken) begin
      pop_wait = ((images_seen / 12) % 3 == 1) ? 0 : $urandom_range(0, 16);
      if (!held_once && images_seen == 30) begin
        hold_left = LONG_HOLD;
        held_once = 1'b1;
      end
    end
    if (hold_left > 0) begin
      hold_left--;
      pop <= 1'b0;
    end else if (pop_wait > 0) begin
      pop_wait--;
      pop <= 1'b0;
    end else begin
      pop <= rst_ni;
    end
  end

  initial begin
    int unsigned queued;
    int unsigned len;
    for (int i = 0; i < TAB_DEPTH; i++) log_fraction[i] = fraction_entry(i);
    sum_model   = '0;
    count_model = '0;

    // Directed images, one pixel each unless noted.
    queue_pixel(16'd0, 16'd0, 1'b1, 1'b1, 1'b0);          // both samples zero
    queue_pixel(16'd0, 16'hFFFF, 1'b1, 1'b1, 1'b0);       // only x zero: adds y
    queue_pixel(16'hFFFF, 16'd0, 1'b1, 1'b1, 1'b0);       // only y zero: adds nothing
    queue_pixel(16'hFFFF, 16'd1, 1'b1, 1'b1, 1'b0);       // largest positive log term
    queue_pixel(16'd1, 16'hFFFF, 1'b1, 1'b1, 1'b0);       // largest negative log term
    queue_pixel(16'd40000, 16'd40000, 1'b1, 1'b1, 1'b0);  // equal samples
    queue_pixel(16'd1000, 16'd1001, 1'b1, 1'b1, 1'b0);    // rounding may go negative
    queue_pixel(16'd1001, 16'd1000, 1'b1, 1'b1, 1'b0);
    queue_pixel(16'd3, 16'd4, 1'b1, 1'b1, 1'b0);
    queue_pixel(16'd5, 16'd7, 1'b0, 1'b1, 1'b0);          // unmasked last, empty count
    queue_pixel(16'd300, 16'd200, 1'b1, 1'b0, 1'b0);      // image with an unmasked second pixel
    queue_pixel(16'd7, 16'd9, 1'b0, 1'b0, 1'b0);
    queue_pixel(16'hFFFF, 16'hFFFF, 1'b1, 1'b1, 1'b0);
    queue_pixel(16'd12345, 16'd54321, 1'b0, 1'b0, 1'b0);  // nothing masked at all
    queue_pixel(16'h5555, 16'hAAAA, 1'b0, 1'b1, 1'b0);
    queue_pixel(16'hAAAA, 16'h5555, 1'b1, 1'b0, 1'b0);
    queue_pixel(16'h8000, 16'h7FFF, 1'b1, 1'b1, 1'b0);

    // Random images, mostly short, now and then a long one. At the start and again
    // partway through, the sender waits for every outstanding result first.
    queued = 0;
    while (queued < RANDOM_PIXELS) begin
      len = ($urandom_range(0, 15) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 12);
      for (int k = 0; k < len; k++) begin
        queue_pixel(random_sample(), random_sample(), $urandom_range(0, 7) != 0,
                    k == len - 1, queued == 0 || (queued >= 800 && k == 0 && queued < 815));
        queued++;
      end
    end

    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    wait (pending_pixels.size() == 0 && !has_pixel);
    wait (expected_means.size() == 0);
    repeat (200) @(posedge clk_i);

    if (expected_means.size() != 0) begin
      mismatches++;
      $display("%0d results never arrived", expected_means.size());
    end
    $display("%0d pixels in %0d images, %0d masked pixels with a zero sample,",
             pixels_sent, images_seen, zero_pairs);
    $display("%0d zero means, input backpressure seen: %0d, %0d mismatches",
             empty_means, saw_full, mismatches);
    if (mismatches == 0) begin
      $display("i_divergence_accumulator_unit test passed");
    end else begin
      $display("i_divergence_accumulator_unit test failed");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/ida_pkg.sv
rtl/ida_front.sv
rtl/ida_queue.sv
rtl/ida_back.sv
rtl/i_divergence_accumulator_unit.sv
tb/i_divergence_accumulator_unit_test.sv
